// File: rtl/core/pidl_pkg.sv
package pidl_pkg;

  localparam int PIDL_CAPACITY = 32;
  localparam int KIND_W = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_INSERT     = 3'd3,
    KIND_ERASE      = 3'd4,
    KIND_READ       = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_ctrl_t;

endpackage

// File: rtl/core/pidl_if.sv
interface pidl_op_if import pidl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink (input valid, input kind, input position, input value, output ready);
endinterface

interface pidl_result_if import pidl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output status, output count, output read_value, input ready);
  modport sink (input valid, input status, input count, input read_value, output ready);
endinterface

// File: rtl/core/pidl_cell.sv
module pidl_cell import pidl_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IW = 5
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [IW-1:0]           at,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] left,
  input  logic signed [VAL_W-1:0] right,
  output logic signed [VAL_W-1:0] word,
  output logic signed [VAL_W-1:0] rd
);

  localparam logic [IW-1:0] ME = IW'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (ME == at) begin
        word <= value;
      end else if (ME > at) begin
        word <= left;
      end
    end else if (ctrl.del && (ME >= at)) begin
      word <= right;
    end
  end

  assign rd = (ctrl.rd && (ME == at)) ? word : '0;

endmodule

// File: rtl/core/pidl_ctrl.sv
module pidl_ctrl import pidl_pkg::*; #(
  parameter int CAPACITY = PIDL_CAPACITY,
  parameter int IW = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  pidl_op_if.sink                 op,
  pidl_result_if.source           result,
  input  logic signed [VAL_W-1:0] read_word,
  output cell_ctrl_t              ctrl,
  output logic [IW-1:0]           at
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CMPW-1:0]   cnt_w;
  logic [CMPW-1:0]   cnt_res_w;
  logic [CMPW-1:0]   pos_w;
  logic              full;
  logic              empty;
  logic              accept;
  kind_t             k;
  status_t           status_c;
  cell_ctrl_t        ctrl_c;
  logic [IW-1:0]     at_c;

  assign accept = op.valid && op.ready;
  assign op.ready = !result.valid || result.ready;
  assign k = kind_t'(op.kind);
  assign cnt_w = CMPW'(count);
  assign pos_w = CMPW'(op.position);
  assign full = (cnt_w == CMPW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    status_c = ST_OK;
    ctrl_c = '0;
    at_c = '0;
    count_next = count;
    case (k)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          ctrl_c.ins = 1'b1;
          at_c = (k == KIND_PUSH_BACK) ? cnt_w[IW-1:0] : '0;
          count_next = count + CW'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          ctrl_c.del = 1'b1;
          count_next = count - CW'(1);
        end
      end
      KIND_INSERT: begin
        at_c = pos_w[IW-1:0];
        if (pos_w > cnt_w) begin
          status_c = ST_RANGE;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          ctrl_c.ins = 1'b1;
          count_next = count + CW'(1);
        end
      end
      KIND_ERASE, KIND_READ: begin
        at_c = pos_w[IW-1:0];
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_c = ST_RANGE;
        end else if (k == KIND_ERASE) begin
          ctrl_c.del = 1'b1;
          count_next = count - CW'(1);
        end else begin
          ctrl_c.rd = 1'b1;
        end
      end
      default: begin
        status_c = ST_RANGE;
      end
    endcase
  end

  assign ctrl = accept ? ctrl_c : '0;
  assign at = at_c;
  assign cnt_res_w = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      result.valid <= 1'b0;
    end else begin
      result.valid <= accept || (result.valid && !result.ready);
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status <= status_c;
      result.count <= cnt_res_w[CNT_W-1:0];
      result.read_value <= read_word;
    end
  end

endmodule

// File: rtl/core/positional_insert_delete_list.sv
// positional_insert_delete_list: ordered list of signed 32-bit words, up to CAPACITY
// op channel: kind, position, value; one operation per item
// result channel: status, count after the operation, read_value (zero unless ok read)
// every op item gives exactly one result item
// the result is registered: result valid in the cycle after the op item is accepted
// throughput: one item per cycle unless stalled; each cell compares its index with the op
// position and shifts in parallel with its neighbors, so no op takes longer
// op.ready is low only while a result waits in the output register and
// result.ready is low; the list holds still while stalled
// reset clears the element count and the result valid; stored words are
// not cleared, positions at or above count are never read
module positional_insert_delete_list import pidl_pkg::*; #(
  parameter int CAPACITY = PIDL_CAPACITY
) (
  input logic           clk,
  input logic           rst,
  pidl_op_if.sink       op,
  pidl_result_if.source result
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cell_ctrl_t              ctrl;
  logic [IW-1:0]           at;
  logic signed [VAL_W-1:0] word [CAPACITY];
  logic signed [VAL_W-1:0] rd [CAPACITY];
  logic signed [VAL_W-1:0] read_word;

  pidl_ctrl #(.CAPACITY(CAPACITY), .IW(IW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .result    (result),
    .read_word (read_word),
    .ctrl      (ctrl),
    .at        (at)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = word[i+1];
    end
    pidl_cell #(.INDEX(i), .IW(IW)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .at    (at),
      .value (op.value),
      .left  (left),
      .right (right),
      .word  (word[i]),
      .rd    (rd[i])
    );
  end

  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | rd[i];
    end
  end

endmodule

// File: rtl/core/pidl_checker.sv
module pidl_checker import pidl_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    op_valid,
  input logic                    op_ready,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic [STAT_W-1:0]       status,
  input logic [CNT_W-1:0]        count,
  input logic signed [VAL_W-1:0] read_value
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> result_valid)
    else $error("accepted item gave no result");

  a_ready_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> (result_valid && !result_ready))
    else $error("op not ready without a stalled result");

  a_zero_read_on_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != ST_OK)) |-> (read_value == '0))
    else $error("read value not zero on error status");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(count) && $stable(status))
    else $error("stalled result changed");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (
  .clk          (clk),
  .rst          (rst),
  .op_valid     (op.valid),
  .op_ready     (op.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.status),
  .count        (result.count),
  .read_value   (result.read_value)
);

// File: dv/positional_insert_delete_list_test.sv
`timescale 1ns / 100ps

module positional_insert_delete_list_test import pidl_pkg::*; ();

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int BURST_LEN = 90;

  typedef struct {
    status_t                 status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] read_value;
  } list_result_t;

  class list_mirror;
    logic signed [VAL_W-1:0] words [PIDL_CAPACITY];
    int                      count;
    int                      errors;
    list_result_t            pending_results [$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void open_gap(int at);
      for (int i = count; i > at; i--) words[i] = words[i-1];
    endfunction

    function void close_gap(int at);
      for (int i = at; i + 1 < count; i++) words[i] = words[i+1];
    endfunction

    function void apply_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                           logic signed [VAL_W-1:0] value);
      list_result_t r;
      int           p;
      int           at;
      p = int'(position);
      r.status = ST_OK;
      r.read_value = '0;
      case (kind)
        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
          if (count >= PIDL_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            at = (kind == KIND_PUSH_BACK) ? count : 0;
            open_gap(at);
            words[at] = value;
            count++;
          end
        end
        KIND_POP_FRONT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            close_gap(0);
            count--;
          end
        end
        KIND_INSERT: begin
          if (p > count) begin
            r.status = ST_RANGE;
          end else if (count >= PIDL_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            open_gap(p);
            words[p] = value;
            count++;
          end
        end
        KIND_ERASE, KIND_READ: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if (p >= count) begin
            r.status = ST_RANGE;
          end else if (kind == KIND_ERASE) begin
            close_gap(p);
            count--;
          end else begin
            r.read_value = words[p];
          end
        end
        default: begin
          r.status = ST_RANGE;
        end
      endcase
      r.count = count[CNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [CNT_W-1:0] cnt,
                               logic signed [VAL_W-1:0] read_value);
      list_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d count %0d read_value %0d",
               status, cnt, read_value);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
      if (read_value !== e.read_value) begin
        $error("read_value: expected %0d, actual %0d", e.read_value, read_value);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  bit         hold_req;
  int         idle_pct;
  int         stall_pct;
  int         cycle_count;
  list_mirror mirror;

  pidl_op_if     op_ch();
  pidl_result_if res_ch();

  positional_insert_delete_list u_dut (
    .clk    (clk),
    .rst    (rst),
    .op     (op_ch),
    .result (res_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_insert_delete_list_test: done, errors");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      mirror.check_result(res_ch.status, res_ch.count, res_ch.read_value);
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] position,
                         input logic signed [VAL_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.kind <= kind;
    op_ch.position <= position;
    op_ch.value <= value;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    mirror.apply_op(kind, position, value);
  endtask

  task automatic wait_drained();
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_results.size() != 0) @(posedge clk);
  endtask

  // alternating bursts that grow toward full and shrink toward empty
  task automatic run_random(input int n);
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    int                      r;
    bit                      grow;
    bit                      add;
    for (int i = 0; i < n; i++) begin
      grow = ((i / BURST_LEN) % 2) == 0;
      r = $urandom_range(99);
      if (r < 4) begin
        kind = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
      end else if (r < 18) begin
        kind = KIND_READ;
      end else begin
        add = (r < 80) ? grow : !grow;
        if (add) begin
          case ($urandom_range(2))
            0: kind = KIND_PUSH_BACK;
            1: kind = KIND_PUSH_FRONT;
            default: kind = KIND_INSERT;
          endcase
        end else begin
          kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_ERASE;
        end
      end
      if ($urandom_range(99) < 12) position = POS_W'($urandom_range(63));
      else position = POS_W'($urandom_range(mirror.count));
      case ($urandom_range(24))
        0: value = 32'sh7fffffff;
        1: value = 32'sh80000000;
        2: value = '0;
        3: value = -1;
        default: value = $urandom;
      endcase
      send_op(kind, position, value);
    end
  endtask

  initial begin
    mirror = new();
    rst <= 1'b1;
    hold_req <= 1'b0;
    op_ch.valid <= 1'b0;
    op_ch.kind <= KIND_PUSH_BACK;
    op_ch.position <= '0;
    op_ch.value <= '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list and range errors, plus pushes, inserts, reads, erases and spare kinds
    send_op(KIND_READ, 6'd0, 32'sd5);
    send_op(KIND_POP_FRONT, 6'd0, 32'sd0);
    send_op(KIND_ERASE, 6'd0, 32'sd0);
    send_op(KIND_INSERT, 6'd1, 32'sd7);
    send_op(KIND_INSERT, 6'd63, 32'sd7);
    send_op(KIND_PUSH_BACK, 6'd63, 32'sh7fffffff);
    send_op(KIND_PUSH_FRONT, 6'd0, 32'sh80000000);
    send_op(KIND_INSERT, 6'd2, 32'sd1);
    send_op(KIND_INSERT, 6'd1, -32'sd1);
    for (int i = 0; i < 5; i++) send_op(KIND_READ, i[POS_W-1:0], 32'sd0);
    send_op(KIND_READ, 6'd63, 32'sd0);
    send_op(KIND_ERASE, 6'd4, 32'sd0);
    send_op(KIND_ERASE, 6'd1, 32'sd0);
    send_op(KIND_SPARE_A, 6'd0, 32'sd3);
    send_op(KIND_SPARE_B, 6'd63, -32'sd3);
    send_op(KIND_POP_FRONT, 6'd0, 32'sd0);
    send_op(KIND_READ, 6'd0, 32'sd0);
    send_op(KIND_ERASE, 6'd1, 32'sd0);
    send_op(KIND_ERASE, 6'd0, 32'sd0);
    send_op(KIND_READ, 6'd0, 32'sd0);
    wait_drained();

    run_random(60);
    hold_req <= 1'b1;
    run_random(215);
    wait_drained();

    idle_pct = 72;
    stall_pct = 0;
    run_random(275);
    wait_drained();

    idle_pct = 0;
    stall_pct = 72;
    run_random(275);
    wait_drained();

    idle_pct = 9;
    stall_pct = 9;
    run_random(275);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
      $display("positional_insert_delete_list_test: done, clean");
    end else begin
      $display("positional_insert_delete_list_test: done, errors");
    end
    $finish;
  end

endmodule
